[rtl/core/ihw_pkg.sv]
// Shared types, constants and the hex digit function for the Intel HEX record writer.
package ihw_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int CNT_W        = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    // byte slots of a record: count, addr hi, addr lo, type, data..., checksum
    localparam int FIRST_DATA_SLOT = 4;
    localparam int SLOT_W       = $clog2(RECORD_BYTES + FIRST_DATA_SLOT + 1);

    localparam logic [15:0] ADDR_LIMIT = 16'h7FFF;

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_FIN = 2'd2;

    localparam logic REC_DATA = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h37;  // 'A' - 10

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [15:0] load_address;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic load;   // take a new byte, high nibble first
        logic first;  // first byte of a record: restart the checksum
        logic step;   // shift to the low nibble
    } t_ser_ctl;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + ext;
        end else begin
            hex_char = CH_ALPHA + ext;
        end
    endfunction

endpackage

[rtl/core/ihw_hex_ser.sv]
// Nibble serializer: shifts one byte out as two hex digits and keeps the record sum.
module ihw_hex_ser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ihw_pkg::t_ser_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [6:0]        o_char,
    output logic              o_lo,
    output logic [7:0]        o_sum
);

    logic [7:0] r_digits;
    logic       r_lo;
    logic [7:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= 1'b0;
        end else if (i_ctl.load) begin
            r_lo <= 1'b0;
        end else if (i_ctl.step) begin
            r_lo <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_digits <= i_byte;
            r_sum    <= i_ctl.first ? i_byte : r_sum + i_byte;
        end else if (i_ctl.step) begin
            r_digits <= {r_digits[3:0], 4'h0};
        end
    end

    assign o_char = ihw_pkg::hex_char(r_digits[7:4]);
    assign o_lo   = r_lo;
    assign o_sum  = r_sum;

endmodule

[rtl/core/intel_hex_record_writer_unit.sv]
// Intel HEX record writer: record buffer, record sequencer and output word register.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data) takes one operation
// per word: put a data byte, set the load address, or finish with an end record.
// Output channel (o_out_valid / i_out_ready, payload o_out_data) carries one
// ASCII character per word; last_char marks the final character of an operation.
// A put that does not close a record gives no output. A record with n data
// bytes is 12 + 2n characters, produced one per cycle while the receiver does
// not stall, the hex digits by the nibble serializer. An operation that starts
// a record moves the sequencer to the colon state, which loads the colon into
// the output register. Input is taken only while no record is being produced,
// so the next operation waits until the final newline is loaded.
// The output register holds the current character while the receiver stalls,
// and the sequencer waits with it; the next operation may be taken while the
// final character is still waiting to be read.
// Synchronous reset clears the byte count, the address and all control state;
// the record buffer holds no reset value and only written entries are used.
module intel_hex_record_writer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ihw_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ihw_pkg::t_out_item o_out_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COLON = 2'd1;
    localparam logic [1:0] S_BYTE  = 2'd2;
    localparam logic [1:0] S_NL    = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [ihw_pkg::CNT_W-1:0]   r_count, n_count;
    logic [15:0]                 r_addr, n_addr;
    logic [15:0]                 r_new_addr, n_new_addr;
    logic                        r_set_pend, n_set_pend;
    logic                        r_end_pend, n_end_pend;
    logic                        r_type, n_type;
    logic [ihw_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic                        r_ov, n_ov;
    ihw_pkg::t_out_item          r_out, n_out;
    logic [7:0]                  r_rd_data;
    logic [7:0]                  mem [ihw_pkg::RECORD_BYTES];

    ihw_pkg::t_ser_ctl           ser_ctl;
    logic [7:0]                  ser_byte;
    logic [6:0]                  ser_char;
    logic                        ser_lo;
    logic [7:0]                  ser_sum;

    logic                        in_acc;
    logic                        adv;
    logic                        wr_en;
    logic [ihw_pkg::CNT_W-1:0]   cnt1;
    logic                        put_close;
    logic [16:0]                 addr_sum;
    logic [ihw_pkg::SLOT_W-1:0]  last_slot;
    logic [ihw_pkg::SLOT_W-1:0]  next_slot;
    logic [ihw_pkg::IDX_W-1:0]   rd_idx;
    logic [ihw_pkg::SLOT_W-1:0]  rd_off;

    assign in_acc    = i_in_valid && o_in_ready;
    assign adv       = !r_ov || i_out_ready;
    assign cnt1      = r_count + 1'b1;
    assign addr_sum  = {1'b0, r_addr} + 17'(cnt1);
    assign put_close = (cnt1 >= ihw_pkg::CNT_W'(ihw_pkg::RECORD_BYTES)) ||
                       (addr_sum > {1'b0, ihw_pkg::ADDR_LIMIT});
    assign last_slot = ihw_pkg::SLOT_W'(r_count) + ihw_pkg::SLOT_W'(ihw_pkg::FIRST_DATA_SLOT);
    assign next_slot = (r_state == S_COLON) ? '0 : r_slot + 1'b1;
    // data byte for the next slot is addressed one slot early, read data registered
    assign rd_off    = r_slot - ihw_pkg::SLOT_W'(ihw_pkg::FIRST_DATA_SLOT - 1);
    assign rd_idx    = rd_off[ihw_pkg::IDX_W-1:0];

    always_comb begin
        if (next_slot == '0) begin
            ser_byte = 8'(r_count);
        end else if (next_slot == ihw_pkg::SLOT_W'(1)) begin
            ser_byte = r_addr[15:8];
        end else if (next_slot == ihw_pkg::SLOT_W'(2)) begin
            ser_byte = r_addr[7:0];
        end else if (next_slot == ihw_pkg::SLOT_W'(3)) begin
            ser_byte = {7'd0, r_type};
        end else if (next_slot == last_slot) begin
            ser_byte = 8'd0 - ser_sum;
        end else begin
            ser_byte = r_rd_data;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_new_addr = r_new_addr;
        n_set_pend = r_set_pend;
        n_end_pend = r_end_pend;
        n_type     = r_type;
        n_slot     = r_slot;
        n_ov       = r_ov && !i_out_ready;
        n_out      = r_out;
        ser_ctl    = '0;
        wr_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.opcode)
                        ihw_pkg::OP_PUT: begin
                            wr_en   = 1'b1;
                            n_count = cnt1;
                            if (put_close) begin
                                n_type  = ihw_pkg::REC_DATA;
                                n_state = S_COLON;
                            end
                        end
                        ihw_pkg::OP_SET: begin
                            if (r_count != '0) begin
                                n_type     = ihw_pkg::REC_DATA;
                                n_set_pend = 1'b1;
                                n_new_addr = i_in_data.load_address & ihw_pkg::ADDR_LIMIT;
                                n_state    = S_COLON;
                            end else begin
                                n_addr = i_in_data.load_address & ihw_pkg::ADDR_LIMIT;
                            end
                        end
                        ihw_pkg::OP_FIN: begin
                            n_state = S_COLON;
                            if (r_count != '0) begin
                                n_type     = ihw_pkg::REC_DATA;
                                n_end_pend = 1'b1;
                            end else begin
                                n_type = ihw_pkg::REC_END;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_COLON: begin
                if (adv) begin
                    n_ov          = 1'b1;
                    n_out         = '{out_char: ihw_pkg::CH_COLON, last_char: 1'b0};
                    ser_ctl.load  = 1'b1;
                    ser_ctl.first = 1'b1;
                    n_slot        = '0;
                    n_state       = S_BYTE;
                end
            end
            S_BYTE: begin
                if (adv) begin
                    n_ov  = 1'b1;
                    n_out = '{out_char: ser_char, last_char: 1'b0};
                    if (!ser_lo) begin
                        ser_ctl.step = 1'b1;
                    end else if (r_slot == last_slot) begin
                        n_state = S_NL;
                    end else begin
                        ser_ctl.load = 1'b1;
                        n_slot       = next_slot;
                    end
                end
            end
            S_NL: begin
                if (adv) begin
                    n_ov       = 1'b1;
                    n_out      = '{out_char: ihw_pkg::CH_NL, last_char: !r_end_pend};
                    n_count    = '0;
                    n_addr     = r_set_pend ? r_new_addr : r_addr + 16'(r_count);
                    n_set_pend = 1'b0;
                    if (r_end_pend) begin
                        n_end_pend = 1'b0;
                        n_type     = ihw_pkg::REC_END;
                        n_state    = S_COLON;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_addr     <= '0;
            r_set_pend <= 1'b0;
            r_end_pend <= 1'b0;
            r_type     <= ihw_pkg::REC_DATA;
            r_slot     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_addr     <= n_addr;
            r_set_pend <= n_set_pend;
            r_end_pend <= n_end_pend;
            r_type     <= n_type;
            r_slot     <= n_slot;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_addr <= n_new_addr;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ihw_pkg::IDX_W-1:0]] <= i_in_data.data_byte;
        end
        r_rd_data <= mem[rd_idx];
    end

    ihw_hex_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ser_ctl),
        .i_byte  (ser_byte),
        .o_char  (ser_char),
        .o_lo    (ser_lo),
        .o_sum   (ser_sum)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // buffer never holds a full record between operations
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < ihw_pkg::CNT_W'(ihw_pkg::RECORD_BYTES)))
        else $error("byte count reached record size while idle");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTE) |-> (r_slot <= last_slot))
        else $error("slot ran past checksum");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_set_pend && !r_end_pend))
        else $error("pending flush work left while idle");

    // a word marked last is only loaded as the closing newline
    a_last_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.last_char) |-> (r_out.out_char == ihw_pkg::CH_NL))
        else $error("last word is not a newline");

endmodule

[bench/tb_intel_hex_record_writer_unit.sv]
// Testbench for the Intel HEX record writer: directed and random operations, predicted text, word-by-word check.
module tb_intel_hex_record_writer_unit;
    import ihw_pkg::*;

    localparam logic [1:0]   OP_NONE      = 2'd3;  // unused code, block ignores it
    localparam logic [127:0] HEX_ASCII    = "0123456789ABCDEF";
    localparam int           STALL_CYCLES = 400;
    localparam int           DRAIN_CYCLES = 20;
    localparam int           PHASE_OPS    = 30;
    localparam int           BURST_PUTS   = 40;

    // Predicts the record text and holds the characters still owed by the block.
    class hex_text_board;
        logic [7:0]  rec_bytes [RECORD_BYTES];
        int          fill;
        logic [15:0] rec_addr;
        t_out_item   pending_chars [$];
        int          ops_taken;
        int          records;
        int          chars_checked;
        int          bad_chars;

        function new();
            fill          = 0;
            rec_addr      = '0;
            ops_taken     = 0;
            records       = 0;
            chars_checked = 0;
            bad_chars     = 0;
        endfunction

        function void push_char(logic [6:0] ch);
            t_out_item c;
            c.out_char  = ch;
            c.last_char = 1'b0;
            pending_chars.push_back(c);
        endfunction

        function void push_byte(logic [7:0] b, inout logic [7:0] sum);
            push_char(HEX_ASCII[(15 - int'(b[7:4])) * 8 +: 7]);
            push_char(HEX_ASCII[(15 - int'(b[3:0])) * 8 +: 7]);
            sum = sum + b;
        endfunction

        function void emit_record(logic rec_type);
            logic [7:0] sum;
            int         n;
            sum = '0;
            n   = fill;
            push_char(CH_COLON);
            push_byte(8'(n), sum);
            push_byte(rec_addr[15:8], sum);
            push_byte(rec_addr[7:0], sum);
            push_byte({7'd0, rec_type}, sum);
            for (int i = 0; i < n; i++) begin
                push_byte(rec_bytes[i], sum);
            end
            push_byte(8'(~sum + 8'd1), sum);
            push_char(CH_NL);
            rec_addr = rec_addr + 16'(n);  // 16-bit wrap, no re-mask
            fill     = 0;
            records++;
        endfunction

        function void note_op(t_in_item w);
            int        owed;
            t_out_item tail;
            owed = pending_chars.size();
            ops_taken++;
            case (w.opcode)
                OP_PUT: begin
                    rec_bytes[fill] = w.data_byte;
                    fill++;
                    if (fill >= RECORD_BYTES || int'(rec_addr) + fill > int'(ADDR_LIMIT)) begin
                        emit_record(REC_DATA);
                    end
                end
                OP_SET: begin
                    if (fill != 0) begin
                        emit_record(REC_DATA);
                    end
                    rec_addr = w.load_address & ADDR_LIMIT;
                end
                OP_FIN: begin
                    if (fill != 0) begin
                        emit_record(REC_DATA);
                    end
                    emit_record(REC_END);
                end
                default: begin
                end
            endcase
            if (pending_chars.size() > owed) begin
                tail = pending_chars.pop_back();
                tail.last_char = 1'b1;
                pending_chars.push_back(tail);
            end
        endfunction

        function void check_char(t_out_item got);
            t_out_item want;
            if (pending_chars.size() == 0) begin
                bad_chars++;
                if (bad_chars <= 10) begin
                    $display("unexpected word: char %h last %b", got.out_char, got.last_char);
                end
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (got.out_char !== want.out_char || got.last_char !== want.last_char) begin
                    bad_chars++;
                    if (bad_chars <= 10) begin
                        $display("mismatch at word %0d: char exp %h got %h, last exp %b got %b",
                                 chars_checked, want.out_char, got.out_char,
                                 want.last_char, got.last_char);
                    end
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    int        sender_idle_pct = 0;
    int        recv_idle_pct   = 0;
    bit        stall_req       = 1'b0;
    int        stall_left      = 0;

    hex_text_board board = new();

    intel_hex_record_writer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_req) begin
            stall_left = STALL_CYCLES;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                board.note_op(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_char(o_out_data);
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_intel_hex_record_writer_unit: FAIL");
        $finish;
    end

    function automatic t_in_item make_op(logic [1:0] op, logic [7:0] d, logic [15:0] a);
        t_in_item w;
        w.opcode       = op;
        w.data_byte    = d;
        w.load_address = a;
        return w;
    endfunction

    // mostly puts so records fill up; sets often land near the 15-bit limit
    function automatic t_in_item random_op();
        t_in_item w;
        int       r;
        r = $urandom_range(99);
        w = make_op(OP_PUT, 8'($urandom), 16'($urandom));
        if (r >= 80 && r < 86) begin
            w.opcode = OP_SET;
            if ($urandom_range(1) == 1) begin
                w.load_address = 16'h7FE0 + 16'($urandom_range(31));
            end
        end else if (r >= 86 && r < 91) begin
            w.opcode = OP_FIN;
        end else if (r >= 91 && r < 96) begin
            w.opcode = OP_NONE;
        end
        return w;
    endfunction

    task automatic send_op(t_in_item w);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic run_random_phase(int snd_pct, int rcv_pct);
        t_in_item w;
        int       n;
        sender_idle_pct = snd_pct;
        recv_idle_pct   = rcv_pct;
        n = 0;
        while (n < PHASE_OPS) begin
            w = random_op();
            send_op(w);
            if (w.opcode != OP_NONE) begin
                n++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 17;
        recv_idle_pct   = 17;
        send_op(make_op(OP_NONE, 8'hFF, 16'hFFFF));   // ignored code right after reset
        send_op(make_op(OP_FIN,  8'hFF, 16'hFFFF));   // end record with nothing open
        send_op(make_op(OP_PUT,  8'h00, 16'hFFFF));
        send_op(make_op(OP_PUT,  8'hFF, 16'h0000));
        send_op(make_op(OP_FIN,  8'h00, 16'h0000));   // flush then end record
        send_op(make_op(OP_SET,  8'hFF, 16'h1234));   // empty flush
        send_op(make_op(OP_PUT,  8'h80, 16'h0000));
        send_op(make_op(OP_SET,  8'h00, 16'hFFFF));   // flush, address masked to 0x7FFF
        send_op(make_op(OP_PUT,  8'hA5, 16'h0000));   // crosses the limit: one-byte record
        send_op(make_op(OP_PUT,  8'h5A, 16'hFFFF));   // address now above the limit
        send_op(make_op(OP_NONE, 8'h00, 16'h0000));
        send_op(make_op(OP_SET,  8'h12, 16'h7FFD));
        send_op(make_op(OP_PUT,  8'h01, 16'h5555));
        send_op(make_op(OP_PUT,  8'h7F, 16'hAAAA));
        send_op(make_op(OP_PUT,  8'hFE, 16'h0000));   // third byte reaches 0x8000
        send_op(make_op(OP_FIN,  8'hC3, 16'h8000));   // end record above the limit
        send_op(make_op(OP_SET,  8'h00, 16'h0000));

        run_random_phase(0, 0);
        run_random_phase(71, 0);
        run_random_phase(0, 71);
        run_random_phase(17, 17);

        // long receiver hold-off while puts keep coming, so input backs up
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        stall_req       = 1'b1;
        for (int i = 0; i < BURST_PUTS; i++) begin
            send_op(make_op(OP_PUT, 8'($urandom), 16'($urandom)));
        end
        send_op(make_op(OP_FIN, 8'($urandom), 16'($urandom)));
        i_in_valid <= 1'b0;
        // let the final operation be noted before waiting on the queue
        @(posedge i_clk);

        while (board.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d operations, %0d records, %0d characters checked",
                 board.ops_taken, board.records, board.chars_checked);
        $display("idle mixes: none, sender 71%%, receiver 71%%, both 17%%, one %0d-cycle hold-off",
                 STALL_CYCLES);
        if (board.bad_chars == 0 && board.pending_chars.size() == 0) begin
            $display("tb_intel_hex_record_writer_unit: PASS");
        end else begin
            $display("%0d bad words, %0d words never seen", board.bad_chars,
                     board.pending_chars.size());
            $display("tb_intel_hex_record_writer_unit: FAIL");
        end
        $finish;
    end

endmodule
